// ----- rtl/cfse_pkg.sv -----
`timescale 1ns / 1ps

package cfse_pkg;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_START = 2'd1,
    CMD_SLOT  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    CFG_LOAD_ADDRESS  = 3'd0,
    CFG_SLIDE         = 3'd1,
    CFG_OFFSET_FORMAT = 3'd2,
    CFG_IMPORT_COUNT  = 3'd3,
    CFG_PAGE_SIZE     = 3'd4
  } cfg_idx_e;

  localparam logic [15:0] PAGE_SIZE_RESET = 16'd16384;
  localparam logic [15:0] PAGE_START_NONE = 16'hFFFF;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [9:0]  import_index;
    logic [63:0] import_address;
    logic [63:0] seg_offset;
    logic [15:0] page_index;
    logic [15:0] page_start;
    logic [63:0] slot_word;
  } in_item_t;

  typedef struct packed {
    logic        is_write;
    logic [63:0] write_address;
    logic [63:0] write_value;
    logic        bad_ordinal;
    logic        chain_end;
    logic [63:0] next_read_address;
  } out_item_t;

endpackage

// ----- rtl/chained_fixup_slot_engine_unit.sv -----
`timescale 1ns / 1ps

// chained fixup slot engine, 64-bit pointer formats
// channels: in (valid/ready, in_item_t beat), out (valid/ready, out_item_t beat)
// and a cfg write channel (index + data) that is always ready
// a load beat writes the import table memory, a start beat sets the chain
// address, a slot beat produces one out beat with the fixed-up pointer and the
// next slot address; load and start beats produce no out beat
// a slot beat passes the second stage register and then the out register
// throughput: one beat per cycle unless out stalls; the second stage reads the
// table data and updates the chain address register, so each slot sees the
// address left by the beat just ahead of it
// stall: while out is held and full, a slot beat in the second stage holds and
// in_ready_o drops once that stage is occupied; one beat can still enter behind
// the waiting result
// reset: clears the chain address to zero, the config registers to their
// defaults (page size 16384) and all valid flags; the import table keeps no
// reset value and needs no clearing pass
module chained_fixup_slot_engine_unit import cfse_pkg::*; #(
  parameter int IMPORT_SLOTS = 1024
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  localparam int AW = (IMPORT_SLOTS > 1) ? $clog2(IMPORT_SLOTS) : 1;
  localparam logic [24:0] SlotsW = 25'(IMPORT_SLOTS);

  logic [63:0] load_address_q;
  logic [63:0] slide_q;
  logic        offset_format_q;
  logic [10:0] import_count_q;
  logic [15:0] page_size_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_address_q  <= '0;
      slide_q         <= '0;
      offset_format_q <= 1'b0;
      import_count_q  <= '0;
      page_size_q     <= PAGE_SIZE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_LOAD_ADDRESS:  load_address_q  <= cfg_data_i;
        CFG_SLIDE:         slide_q         <= cfg_data_i;
        CFG_OFFSET_FORMAT: offset_format_q <= cfg_data_i[0];
        CFG_IMPORT_COUNT:  import_count_q  <= cfg_data_i[10:0];
        CFG_PAGE_SIZE:     page_size_q     <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // first stage: accept, table access, start address partial sums
  logic        in_acc;
  logic [23:0] ordinal;
  logic        load_ok;
  logic        bad;
  logic [31:0] prod;
  logic [63:0] base;
  logic [63:0] entry;

  assign in_acc  = in_valid_i && in_ready_o;
  assign ordinal = in_data_i.slot_word[23:0];
  assign load_ok = {15'b0, in_data_i.import_index} < SlotsW;
  assign bad     = in_data_i.slot_word[63]
                   && (ordinal >= {13'b0, import_count_q}
                       || {1'b0, ordinal} >= SlotsW);
  assign prod    = {16'b0, in_data_i.page_index} * {16'b0, page_size_q};
  assign base    = load_address_q + in_data_i.seg_offset
                   + {48'b0, in_data_i.page_start};

  cfse_ram #(
    .WIDTH (64),
    .DEPTH (IMPORT_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (in_acc && in_data_i.cmd == CMD_LOAD && load_ok),
    .waddr_i (AW'(32'(in_data_i.import_index))),
    .wdata_i (in_data_i.import_address),
    .re_i    (in_acc && in_data_i.cmd == CMD_SLOT),
    .raddr_i (AW'(32'(ordinal))),
    .rdata_o (entry)
  );

  // second stage
  logic        s1_valid_q;
  logic [1:0]  s1_cmd_q;
  logic        s1_skip_q;
  logic        s1_bad_q;
  logic [63:0] s1_raw_q;
  logic [31:0] s1_prod_q;
  logic [63:0] s1_base_q;
  logic [63:0] chain_q;
  logic [63:0] chain_d;
  logic        out_valid_q;
  out_item_t   out_q;
  out_item_t   out_d;
  logic        s1_res;
  logic        s1_go;

  assign s1_res     = s1_cmd_q == CMD_SLOT;
  assign s1_go      = s1_valid_q && (!s1_res || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_cmd_q  <= in_data_i.cmd;
      s1_skip_q <= in_data_i.page_start == PAGE_START_NONE;
      s1_bad_q  <= bad;
      s1_raw_q  <= in_data_i.slot_word;
      s1_prod_q <= prod;
      s1_base_q <= base;
    end
  end

  logic [11:0] nxt;
  logic [63:0] step_addr;
  logic [63:0] bind_val;
  logic [63:0] rebase_val;

  assign nxt        = s1_raw_q[62:51];
  assign step_addr  = chain_q + {50'b0, nxt, 2'b00};
  assign bind_val   = (entry != 64'd0) ? entry + {56'b0, s1_raw_q[31:24]} : 64'd0;
  assign rebase_val = ((offset_format_q ? load_address_q : slide_q)
                       + {28'b0, s1_raw_q[35:0]}) | {s1_raw_q[43:36], 56'b0};

  always_comb begin
    chain_d                 = chain_q;
    out_d.is_write          = 1'b1;
    out_d.write_address     = chain_q;
    out_d.write_value       = s1_raw_q[63] ? bind_val : rebase_val;
    out_d.bad_ordinal       = 1'b0;
    out_d.chain_end         = nxt == 12'd0;
    out_d.next_read_address = step_addr;
    case (s1_cmd_q)
      CMD_START: begin
        if (!s1_skip_q) begin
          chain_d = s1_base_q + {32'b0, s1_prod_q};
        end
      end
      CMD_SLOT: begin
        if (s1_bad_q) begin
          out_d.is_write          = 1'b0;
          out_d.write_value       = 64'd0;
          out_d.bad_ordinal       = 1'b1;
          out_d.chain_end         = 1'b1;
          out_d.next_read_address = chain_q;
        end else begin
          chain_d = step_addr;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      chain_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        chain_q <= chain_d;
      end
      if (s1_go && s1_res) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go && s1_res) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/cfse_ram.sv -----
`timescale 1ns / 1ps

module cfse_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/cfse_checker.sv -----
`timescale 1ns / 1ps

module cfse_checker import cfse_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("out beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("out beat changed while stalled");

  a_bad_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.bad_ordinal
    |-> out_data_o.chain_end && !out_data_o.is_write && out_data_o.write_value == 64'd0)
    else $error("bad ordinal beat not terminal");

  a_end_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.chain_end
    |-> out_data_o.next_read_address == out_data_o.write_address)
    else $error("chain end with moving address");

  a_step_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.chain_end
    |-> out_data_o.is_write
        && out_data_o.next_read_address != out_data_o.write_address)
    else $error("chain step without address advance");

endmodule

bind chained_fixup_slot_engine_unit cfse_checker u_cfse_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import cfse_pkg::*;

  localparam int SLOTS       = 1024;
  localparam int HOLD_CYCLES = 400;
  localparam int SETTLE      = 6;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_BEATS = 255;

  class fixup_tracker;
    logic [63:0] imports [SLOTS];
    logic [63:0] chain_addr;
    logic [63:0] image_base;
    logic [63:0] slide_amt;
    logic        offset_fmt;
    logic [10:0] import_cnt;
    logic [15:0] page_bytes;
    out_item_t   due [$];
    int          fails;

    function new();
      chain_addr = '0;
      image_base = '0;
      slide_amt  = '0;
      offset_fmt = 1'b0;
      import_cnt = '0;
      page_bytes = PAGE_SIZE_RESET;
      fails      = 0;
    endfunction

    function int ordinal_limit();
      return (import_cnt > SLOTS) ? SLOTS : int'(import_cnt);
    endfunction

    function void set_reg(cfg_idx_e idx, logic [63:0] v);
      case (idx)
        CFG_LOAD_ADDRESS:  image_base = v;
        CFG_SLIDE:         slide_amt  = v;
        CFG_OFFSET_FORMAT: offset_fmt = v[0];
        CFG_IMPORT_COUNT:  import_cnt = v[10:0];
        CFG_PAGE_SIZE:     page_bytes = v[15:0];
        default: ;
      endcase
    endfunction

    function void note_beat(in_item_t b);
      out_item_t   r;
      logic [63:0] cur;
      logic [63:0] base;
      logic [11:0] nxt;
      logic [23:0] ord;
      case (b.cmd)
        CMD_LOAD: imports[b.import_index] = b.import_address;
        CMD_START: begin
          if (b.page_start != PAGE_START_NONE)
            chain_addr = image_base + b.seg_offset
                       + {48'd0, b.page_index} * {48'd0, page_bytes} + {48'd0, b.page_start};
        end
        CMD_SLOT: begin
          cur = chain_addr;
          nxt = b.slot_word[62:51];
          ord = b.slot_word[23:0];
          r.write_address = cur;
          r.bad_ordinal   = 1'b0;
          if (b.slot_word[63] && ord >= ordinal_limit()) begin
            r.is_write          = 1'b0;
            r.write_value       = '0;
            r.bad_ordinal       = 1'b1;
            r.chain_end         = 1'b1;
            r.next_read_address = cur;
          end else begin
            if (b.slot_word[63]) begin
              r.write_value = (imports[ord[9:0]] != 0) ?
                              imports[ord[9:0]] + {56'd0, b.slot_word[31:24]} : 64'd0;
            end else begin
              base = offset_fmt ? image_base : slide_amt;
              r.write_value = (base + {28'd0, b.slot_word[35:0]}) | {b.slot_word[43:36], 56'd0};
            end
            chain_addr          = cur + {50'd0, nxt, 2'b00};
            r.is_write          = 1'b1;
            r.chain_end         = (nxt == 0);
            r.next_read_address = chain_addr;
          end
          due = {due, r};
        end
        default: ;
      endcase
    endfunction

    function void check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $error("%s: expected %h, got %h", name, want, got);
        fails++;
      end
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (due.size() == 0) begin
        $error("out beat with nothing pending: %h", got);
        fails++;
        return;
      end
      want = due.pop_front();
      check_field("is_write", 64'(want.is_write), 64'(got.is_write));
      check_field("write_address", want.write_address, got.write_address);
      check_field("write_value", want.write_value, got.write_value);
      check_field("bad_ordinal", 64'(want.bad_ordinal), 64'(got.bad_ordinal));
      check_field("chain_end", 64'(want.chain_end), 64'(got.chain_end));
      check_field("next_read_address", want.next_read_address, got.next_read_address);
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  in_item_t    in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  out_item_t   out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [63:0] cfg_data_i  = '0;

  fixup_tracker track;
  int           sent          = 0;
  int           cycles        = 0;
  int           snd_idle_pct  = 0;
  int           rcv_stall_pct = 0;
  bit           hold_req      = 1'b0;
  bit           hold_ack      = 1'b0;
  int           hold_left     = 0;
  int           stocked [$];

  chained_fixup_slot_engine_unit uut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // out side: check beats, random stalls and the long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left   <= 0;
    end else begin
      if (out_valid_o && out_ready_i) track.check_result(out_data_o);
      if (hold_req != hold_ack) begin
        hold_ack    <= hold_req;
        hold_left   <= HOLD_CYCLES;
        out_ready_i <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left   <= hold_left - 1;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= rcv_stall_pct);
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic in_item_t filler(input cmd_e c);
    in_item_t b;
    b.cmd            = c;
    b.import_index   = 10'($urandom_range(SLOTS - 1));
    b.import_address = rand64();
    b.seg_offset     = rand64();
    b.page_index     = 16'($urandom);
    b.page_start     = 16'($urandom_range(16'hFFFE));
    b.slot_word      = rand64();
    return b;
  endfunction

  function automatic logic [63:0] random_slot(input bit last);
    logic [63:0] r;
    logic [11:0] nxt;
    logic [23:0] ord;
    int          lim;
    int          pick;
    r    = rand64();
    nxt  = last ? 12'd0 : 12'($urandom);
    lim  = track.ordinal_limit();
    pick = $urandom_range(99);
    if (pick < 45 && stocked.size() != 0) begin
      repeat (4) begin
        ord = 24'(stocked[$urandom_range(stocked.size() - 1)]);
        if (ord < lim) return {1'b1, nxt, r[50:24], ord};
      end
    end else if (pick < 57) begin
      ord = ($urandom_range(1) != 0) ? 24'(lim) : 24'($urandom_range(24'hFFFFFF, lim));
      return {1'b1, nxt, r[50:24], ord};
    end
    return {1'b0, nxt, r[50:0]};
  endfunction

  task automatic offer(input in_item_t b);
    if (snd_idle_pct != 0 && $urandom_range(99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    track.note_beat(b);
    if (b.cmd != CMD_NONE) sent++;
  endtask

  task automatic load_import(input logic [9:0] idx, input logic [63:0] addr);
    in_item_t b;
    b = filler(CMD_LOAD);
    b.import_index   = idx;
    b.import_address = addr;
    stocked = {stocked, int'(idx)};
    offer(b);
  endtask

  task automatic start_chain(input logic [63:0] seg, input logic [15:0] pg, input logic [15:0] st);
    in_item_t b;
    b = filler(CMD_START);
    b.seg_offset = seg;
    b.page_index = pg;
    b.page_start = st;
    offer(b);
  endtask

  task automatic read_slot(input logic [63:0] word);
    in_item_t b;
    b = filler(CMD_SLOT);
    b.slot_word = word;
    offer(b);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (track.due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic configure(input logic [63:0] la, input logic [63:0] sl, input logic fmt,
                           input logic [10:0] cnt, input logic [15:0] ps);
    cfg_idx_e    order [5];
    logic [63:0] vals [5];
    order = '{CFG_LOAD_ADDRESS, CFG_SLIDE, CFG_OFFSET_FORMAT, CFG_IMPORT_COUNT, CFG_PAGE_SIZE};
    vals  = '{la, sl, 64'(fmt), 64'(cnt), 64'(ps)};
    for (int i = 0; i < 5; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= order[i];
      cfg_data_i  <= vals[i];
      do @(posedge clk_i); while (!cfg_ready_o);
      track.set_reg(order[i], vals[i]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic directed();
    load_import(10'd0, '1);
    load_import(10'd1023, 64'd0);
    load_import(10'd5, 64'h0123_4567_89ab_cdef);
    offer(filler(CMD_NONE));
    // page without a chain, slots still run from the reset address
    start_chain(rand64(), 16'd3, PAGE_START_NONE);
    read_slot({1'b0, 12'd1, 7'd0, 8'h00, 36'h0_0000_0000});
    read_slot({1'b0, 12'hFFF, 7'h7F, 8'hFF, 36'hF_FFFF_FFFF});
    start_chain('1, 16'hFFFF, 16'hFFFE);
    read_slot({1'b1, 12'hFFF, 19'h7FFFF, 8'hFF, 24'd0});
    read_slot({1'b1, 12'd2, 19'd0, 8'h10, 24'd1023});
    read_slot({1'b1, 12'd1, 19'd0, 8'h00, 24'd5});
    read_slot({1'b1, 12'd7, 19'd0, 8'h00, 24'd1024});
    read_slot({1'b1, 12'hFFF, 19'h7FFFF, 8'hFF, 24'hFFFFFF});
    start_chain(64'd0, 16'd0, 16'd0);
    read_slot({1'b0, 12'd0, 7'd0, 8'h80, 36'h8_0000_0001});
    read_slot(64'd0);
  endtask

  // loads, a start, then a run of slots; some noise and stray beats mixed in
  task automatic run_chain();
    int n;
    int lim;
    lim = track.ordinal_limit();
    if ($urandom_range(99) < 30) begin
      repeat ($urandom_range(1, 4))
        load_import(10'($urandom_range(lim != 0 ? lim - 1 : SLOTS - 1)),
                    ($urandom_range(9) == 0) ? 64'd0 : rand64());
    end
    if ($urandom_range(99) < 4) offer(filler(CMD_NONE));
    if ($urandom_range(99) < 5) start_chain(rand64(), 16'($urandom), PAGE_START_NONE);
    if ($urandom_range(99) < 10) read_slot(random_slot(1'b0));
    start_chain(rand64(), 16'($urandom), 16'($urandom_range(16'hFFFE)));
    n = $urandom_range(1, 8);
    for (int k = 0; k < n; k++)
      read_slot(random_slot(k == n - 1 && $urandom_range(99) < 70));
  endtask

  initial begin
    int goal;
    bit paused;
    track  = new();
    paused = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: configure('0, '0, 1'b0, 11'd1024, PAGE_SIZE_RESET);
        1: configure('1, '1, 1'b1, 11'd0, 16'd0);
        2: configure(rand64(), rand64(), 1'b0, 11'($urandom_range(1, 1024)), 16'hFFFF);
        3: configure(rand64(), rand64(), 1'b1, 11'd1024, 16'($urandom));
        4: configure(rand64(), '1, 1'b0, 11'd1, 16'($urandom));
        default: configure('1, '0, 1'b1, 11'($urandom_range(1024)), 16'hFFFF);
      endcase
      case (p % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 75; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 75; end
        default: begin snd_idle_pct = 34; rcv_stall_pct = 34; end
      endcase
      if (p == 0) directed();
      if (p == 4) hold_req <= ~hold_req;
      goal = sent + PHASE_BEATS;
      while (sent < goal) begin
        if (p == 5 && !paused && sent >= goal - PHASE_BEATS / 2) begin
          settle();
          paused = 1'b1;
        end
        run_chain();
      end
    end
    settle();
    if (track.fails == 0 && track.due.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ----- chained_fixup_slot_engine_unit.f -----
rtl/cfse_pkg.sv
rtl/cfse_ram.sv
rtl/chained_fixup_slot_engine_unit.sv
rtl/cfse_checker.sv
sim/tb.sv
